// ===== rtl/core/vtp_pkg.sv =====
// shared types and constants for the vertex transform and projection block
// no dependencies
`default_nettype none

package vtp_pkg;

    localparam int NUM_CFG_REGS = 8;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 64;
    localparam int COEF_W       = 32;
    localparam int ACC_W        = 64;
    localparam int NUM_COLS     = 4;
    localparam int NUM_ROWS     = 3;

    typedef logic [ACC_W-1:0]      acc_t;
    typedef logic [CFG_DATA_W-1:0] cfg_word_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

    typedef enum logic
    {
        OP_TRANSFORM = 1'b0,
        OP_PROJECT   = 1'b1
    } op_t;

    localparam cfg_word_t CFG_RESET [NUM_CFG_REGS] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

endpackage

`default_nettype wire

// ===== rtl/core/vertex_transform_project.sv =====
// top level of the homogeneous 4x4 vertex transform with perspective divide
// depends on vtp_pkg
`default_nettype none

// A vertex item is taken at every clock edge where start is high; busy is
// always low, so one item per cycle is sustained. Each item comes out on the
// result ports marked by done for one cycle; the receiver cannot stall, so
// nothing is ever held back. The pipeline is a restoring divider pipelined
// one quotient bit per stage (COORD_WIDTH stages) behind an input stage, a
// multiply stage, two adder stages, a magnitude stage and a divider set-up
// stage, followed by an output register. Transform items ride the same
// pipeline so results leave in order. The matrix is written through the cfg
// port (always ready); the user must write it only while no item is in flight,
// which the block does not enforce. Writes to indexes 8 and above are dropped.
module vertex_transform_project #(
    parameter int COORD_WIDTH    = 16,
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire                           clk,
    input  wire                           rst_n,
    // item channel
    input  wire                           start,
    output logic                          busy,
    input  wire                           opcode,
    input  wire  signed [COORD_WIDTH-1:0] vert_x,
    input  wire  signed [COORD_WIDTH-1:0] vert_y,
    input  wire  signed [COORD_WIDTH-1:0] vert_z,
    input  wire                           last_in,
    // configuration channel
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire  vtp_pkg::cfg_idx_t       cfg_index,
    input  wire  vtp_pkg::cfg_word_t      cfg_data,
    // result channel
    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y,
    output logic signed [COORD_WIDTH-1:0] out_z,
    output logic                          clip_flag,
    output logic                          div_fault,
    output logic                          last_out
);
    import vtp_pkg::*;

    localparam int CW      = COORD_WIDTH;
    localparam int WIDE_W  = ACC_W + CW;
    localparam int LATENCY = CW + 7;

    typedef logic [CW-1:0] coord_t;

    // matrix registers
    cfg_word_t cfg_reg [NUM_CFG_REGS];

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CFG_REGS; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_CFG_REGS)))
        begin
            cfg_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // coefficient M[r][c]: two per register, lower column in the low half
    function automatic logic signed [COEF_W-1:0] coef(input int r, input int c);
        logic [2:0] idx;
        idx = 3'((2 * r) + (c >> 1));
        return cfg_reg[idx][COEF_W*(c & 1) +: COEF_W];
    endfunction

    // saturate sign/magnitude to CW bits, result is {clip, value}
    function automatic logic [CW:0] sat_fn(input logic neg, input logic big,
                                           input acc_t m);
        acc_t   lim;
        coord_t val;
        logic   clip;
        lim  = ACC_W'(1) << (CW - 1);
        clip = 1'b0;
        if (neg)
        begin
            if (big || (m > lim))
            begin
                val  = coord_t'(lim);
                clip = 1'b1;
            end
            else
            begin
                val = coord_t'(~m + ACC_W'(1));
            end
        end
        else
        begin
            if (big || (m > (lim - ACC_W'(1))))
            begin
                val  = coord_t'(lim - ACC_W'(1));
                clip = 1'b1;
            end
            else
            begin
                val = coord_t'(m);
            end
        end
        return {clip, val};
    endfunction

    // stage 0: input register
    logic   v0_reg;
    logic   op0_reg, last0_reg;
    coord_t x0_reg, y0_reg, z0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op0_reg   <= opcode;
            last0_reg <= last_in;
            x0_reg    <= vert_x;
            y0_reg    <= vert_y;
            z0_reg    <= vert_z;
        end
    end

    // stage 1: twelve products, one 32 x CW multiplier each
    logic signed [COEF_W+CW-1:0] prod_c [NUM_COLS][NUM_ROWS];
    acc_t prod_reg [NUM_COLS][NUM_ROWS];
    logic v1_reg, op1_reg, last1_reg;

    always_comb
    begin
        for (int c = 0; c < NUM_COLS; c++)
        begin
            prod_c[c][0] = coef(0, c) * $signed(x0_reg);
            prod_c[c][1] = coef(1, c) * $signed(y0_reg);
            prod_c[c][2] = coef(2, c) * $signed(z0_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_COLS; c++)
        begin
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                prod_reg[c][r] <= ACC_W'(prod_c[c][r]);
            end
        end
        op1_reg   <= op0_reg;
        last1_reg <= last0_reg;
    end

    // stage 2: partial sums, translation folded in
    acc_t sa_reg [NUM_COLS];
    acc_t sb_reg [NUM_COLS];
    logic v2_reg, op2_reg, last2_reg;

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_COLS; c++)
        begin
            sa_reg[c] <= prod_reg[c][0] + prod_reg[c][1];
            sb_reg[c] <= prod_reg[c][2] + ACC_W'(coef(3, c));
        end
        op2_reg   <= op1_reg;
        last2_reg <= last1_reg;
    end

    // stage 3: accumulators, wrap modulo 2^64
    acc_t acc_reg [NUM_COLS];
    logic v3_reg, op3_reg, last3_reg;

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_COLS; c++)
        begin
            acc_reg[c] <= sa_reg[c] + sb_reg[c];
        end
        op3_reg   <= op2_reg;
        last3_reg <= last2_reg;
    end

    // stage 4: sign and magnitude, transform results saturated here
    acc_t   magx4_reg, magy4_reg, magw4_reg;
    logic   negx4_reg, negy4_reg, negw4_reg, zero4_reg;
    coord_t tx4_reg, ty4_reg, tz4_reg;
    logic   tclip4_reg;
    logic   v4_reg, op4_reg, last4_reg;

    acc_t      mag_c [NUM_COLS];
    logic [CW:0] tsat_c [3];

    always_comb
    begin
        for (int c = 0; c < NUM_COLS; c++)
        begin
            mag_c[c] = acc_reg[c][ACC_W-1] ? (~acc_reg[c] + ACC_W'(1)) : acc_reg[c];
        end
        for (int c = 0; c < 3; c++)
        begin
            tsat_c[c] = sat_fn(acc_reg[c][ACC_W-1], 1'b0, mag_c[c] >> COEF_FRAC_BITS);
        end
    end

    always_ff @(posedge clk)
    begin
        magx4_reg  <= mag_c[0];
        magy4_reg  <= mag_c[1];
        magw4_reg  <= mag_c[3];
        negx4_reg  <= acc_reg[0][ACC_W-1];
        negy4_reg  <= acc_reg[1][ACC_W-1];
        negw4_reg  <= acc_reg[3][ACC_W-1];
        zero4_reg  <= (acc_reg[3] == '0);
        tx4_reg    <= tsat_c[0][CW-1:0];
        ty4_reg    <= tsat_c[1][CW-1:0];
        tz4_reg    <= tsat_c[2][CW-1:0];
        tclip4_reg <= tsat_c[0][CW] | tsat_c[1][CW] | tsat_c[2][CW];
        op4_reg    <= op3_reg;
        last4_reg  <= last3_reg;
    end

    // divider pipeline: entry 0 is set-up, entry k+1 after quotient bit CW-1-k
    acc_t   rx_reg [CW+1];
    acc_t   ry_reg [CW+1];
    acc_t   dd_reg [CW+1];
    coord_t qx_reg [CW+1];
    coord_t qy_reg [CW+1];
    logic   ovfx_reg [CW+1];
    logic   ovfy_reg [CW+1];
    logic   negx_reg [CW+1];
    logic   negy_reg [CW+1];
    logic   negw_reg [CW+1];
    logic   zero_reg [CW+1];
    coord_t tx_reg [CW+1];
    coord_t ty_reg [CW+1];
    coord_t tz_reg [CW+1];
    logic   tclip_reg [CW+1];
    logic   op_reg [CW+1];
    logic   last_reg [CW+1];
    logic   dv_reg [CW+1];

    logic [WIDE_W-1:0] dsh_c [CW];
    logic              ge_x_c [CW];
    logic              ge_y_c [CW];

    always_comb
    begin
        for (int k = 0; k < CW; k++)
        begin
            dsh_c[k]  = WIDE_W'(dd_reg[k]) << (CW - 1 - k);
            ge_x_c[k] = WIDE_W'(rx_reg[k]) >= dsh_c[k];
            ge_y_c[k] = WIDE_W'(ry_reg[k]) >= dsh_c[k];
        end
    end

    always_ff @(posedge clk)
    begin
        // set-up: quotient of more than CW bits saturates straight away
        rx_reg[0]    <= magx4_reg;
        ry_reg[0]    <= magy4_reg;
        dd_reg[0]    <= magw4_reg;
        qx_reg[0]    <= '0;
        qy_reg[0]    <= '0;
        ovfx_reg[0]  <= WIDE_W'(magx4_reg) >= (WIDE_W'(magw4_reg) << CW);
        ovfy_reg[0]  <= WIDE_W'(magy4_reg) >= (WIDE_W'(magw4_reg) << CW);
        negx_reg[0]  <= negx4_reg;
        negy_reg[0]  <= negy4_reg;
        negw_reg[0]  <= negw4_reg;
        zero_reg[0]  <= zero4_reg;
        tx_reg[0]    <= tx4_reg;
        ty_reg[0]    <= ty4_reg;
        tz_reg[0]    <= tz4_reg;
        tclip_reg[0] <= tclip4_reg;
        op_reg[0]    <= op4_reg;
        last_reg[0]  <= last4_reg;
        for (int k = 0; k < CW; k++)
        begin
            rx_reg[k+1]    <= ge_x_c[k] ? (rx_reg[k] - dsh_c[k][ACC_W-1:0]) : rx_reg[k];
            ry_reg[k+1]    <= ge_y_c[k] ? (ry_reg[k] - dsh_c[k][ACC_W-1:0]) : ry_reg[k];
            qx_reg[k+1]    <= qx_reg[k] | (coord_t'(ge_x_c[k]) << (CW - 1 - k));
            qy_reg[k+1]    <= qy_reg[k] | (coord_t'(ge_y_c[k]) << (CW - 1 - k));
            dd_reg[k+1]    <= dd_reg[k];
            ovfx_reg[k+1]  <= ovfx_reg[k];
            ovfy_reg[k+1]  <= ovfy_reg[k];
            negx_reg[k+1]  <= negx_reg[k];
            negy_reg[k+1]  <= negy_reg[k];
            negw_reg[k+1]  <= negw_reg[k];
            zero_reg[k+1]  <= zero_reg[k];
            tx_reg[k+1]    <= tx_reg[k];
            ty_reg[k+1]    <= ty_reg[k];
            tz_reg[k+1]    <= tz_reg[k];
            tclip_reg[k+1] <= tclip_reg[k];
            op_reg[k+1]    <= op_reg[k];
            last_reg[k+1]  <= last_reg[k];
        end
    end

    // valid bits travel alongside
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            for (int k = 0; k <= CW; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
        end
        else
        begin
            v1_reg    <= v0_reg;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            dv_reg[0] <= v4_reg;
            for (int k = 0; k < CW; k++)
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end
    end

    // output stage: pick transform or projection result, or zeros on a division fault
    logic [CW:0] px_c, py_c;
    logic        done_reg;
    coord_t      ox_reg, oy_reg, oz_reg;
    logic        clip_reg, fault_reg, lasto_reg;

    always_comb
    begin
        px_c = sat_fn(negx_reg[CW] ^ negw_reg[CW], ovfx_reg[CW], ACC_W'(qx_reg[CW]));
        py_c = sat_fn(negy_reg[CW] ^ negw_reg[CW], ovfy_reg[CW], ACC_W'(qy_reg[CW]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_reg[CW];
        end
    end

    always_ff @(posedge clk)
    begin
        lasto_reg <= last_reg[CW];
        if (op_t'(op_reg[CW]) == OP_TRANSFORM)
        begin
            ox_reg    <= tx_reg[CW];
            oy_reg    <= ty_reg[CW];
            oz_reg    <= tz_reg[CW];
            clip_reg  <= tclip_reg[CW];
            fault_reg <= 1'b0;
        end
        else if (zero_reg[CW])
        begin
            ox_reg    <= '0;
            oy_reg    <= '0;
            oz_reg    <= '0;
            clip_reg  <= 1'b0;
            fault_reg <= 1'b1;
        end
        else
        begin
            ox_reg    <= px_c[CW-1:0];
            oy_reg    <= py_c[CW-1:0];
            oz_reg    <= '0;
            clip_reg  <= px_c[CW] | py_c[CW];
            fault_reg <= 1'b0;
        end
    end

    assign done      = done_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_z     = oz_reg;
    assign clip_flag = clip_reg;
    assign div_fault = fault_reg;
    assign last_out  = lasto_reg;

`ifndef NO_ASSERTIONS
    // every accepted item leaves the pipeline marked by done
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("item did not emerge after pipeline latency");

    // nothing leaves that was not taken in
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(dv_reg[CW])) else $error("result strobe without a valid item");

    // a division fault gives zeros and no clip
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && div_fault) |-> (!clip_flag && out_x == '0 && out_y == '0 && out_z == '0))
        else $error("faulted item carries data");

    // projected items have zero z
    a_proj_z: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_reg[CW] && op_reg[CW]) |=> (out_z == '0))
        else $error("projected item has non-zero z");
`endif

endmodule

`default_nettype wire
